// ===== design/sto_pkg.sv =====
package sto_pkg;

    // Field widths
    localparam int KEY_W = 32;
    localparam int OFF_W = 32;
    localparam int ENTRY_W = KEY_W + OFF_W;

    // Default table depth
    localparam int DEPTH_DEFAULT = 32;

    // Operation codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_RECENT = 2'd2,
        MODE_SHIFT  = 2'd3
    } mode_t;

    // Operands of the shared compare / add unit
    typedef struct packed {
        logic [KEY_W-1:0] x;
        logic [KEY_W-1:0] y;
        logic [OFF_W-1:0] a;
        logic [OFF_W-1:0] b;
    } alu_op_t;

    // Results of the shared compare / add unit
    typedef struct packed {
        logic             gt;
        logic             eq;
        logic [OFF_W-1:0] sum;
    } alu_res_t;

endpackage

// ===== design/sorted_time_offset_index.sv =====
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   mode, time_key, offset_value
// out      output     out_valid/out_stall found_offset, dropped
//
// Lookup, insert and shift walk the table one entry per cycle through the single read
// port of the entry RAM and the shared compare/add unit; set recent does not read it.
// Reset clears the entry count and the recent pair; table contents are not cleared.
// in_stall is high while an item is in work; a finished item waits while out_valid and out_stall are both high.
module sorted_time_offset_index
    import sto_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       mode,
    input  logic [KEY_W-1:0] time_key,
    input  logic [OFF_W-1:0] offset_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [OFF_W-1:0] found_offset,
    output logic             dropped
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_SCAN,
        S_LK_REC1,
        S_LK_REC2,
        S_INS_SCAN,
        S_INS_MOVE,
        S_INS_PUT,
        S_SH_SCAN,
        S_SH_REC,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [KEY_W-1:0] q_key_reg, q_key_next;
    logic [OFF_W-1:0] val_reg, val_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    pend_reg, pend_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic [OFF_W-1:0] best_off_reg, best_off_next;
    logic [OFF_W-1:0] found_reg, found_next;
    logic             drop_reg, drop_next;
    logic [KEY_W-1:0] recent_key_reg, recent_key_next;
    logic [OFF_W-1:0] recent_off_reg, recent_off_next;
    logic             out_valid_reg, out_valid_next;
    logic [OFF_W-1:0] found_offset_reg, found_offset_next;
    logic             dropped_reg, dropped_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [OFF_W-1:0]   rd_off;

    alu_op_t  alu_op;
    alu_res_t alu_res;

    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] last_addr;
    logic          table_full;

    // Entry table: {key, offset} per word
    sto_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Shared compare / saturating add
    sto_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    assign rd_key     = ram_rdata[ENTRY_W-1:OFF_W];
    assign rd_off     = ram_rdata[OFF_W-1:0];
    assign cnt_m1     = cnt_reg - CW'(1);
    assign last_addr  = cnt_m1[AW-1:0];
    assign table_full = (cnt_reg == CW'(DEPTH));

    // Operand select for the shared unit
    always_comb
    begin
        alu_op.x = rd_key;
        alu_op.y = q_key_reg;
        alu_op.a = rd_off;
        alu_op.b = val_reg;
        case (state_reg)
            S_LK_REC1:
            begin
                alu_op.x = recent_key_reg;
            end
            S_LK_REC2:
            begin
                alu_op.x = best_key_reg;
                alu_op.y = recent_key_reg;
            end
            S_SH_REC:
            begin
                alu_op.x = recent_key_reg;
                alu_op.a = recent_off_reg;
            end
            default:
            begin
                alu_op.x = rd_key;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        logic          hit_done;
        logic [CW-1:0] hit_pos;

        hit_done          = 1'b0;
        hit_pos           = cnt_reg;
        state_next        = state_reg;
        q_key_next        = q_key_reg;
        val_next          = val_reg;
        cnt_next          = cnt_reg;
        pend_next         = pend_reg;
        pos_next          = pos_reg;
        best_key_next     = best_key_reg;
        best_off_next     = best_off_reg;
        found_next        = found_reg;
        drop_next         = drop_reg;
        recent_key_next   = recent_key_reg;
        recent_off_next   = recent_off_reg;
        out_valid_next    = out_valid_reg & out_stall;
        found_offset_next = found_offset_reg;
        dropped_next      = dropped_reg;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = '0;
        ram_re            = 1'b0;
        ram_raddr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    q_key_next = time_key;
                    val_next   = offset_value;
                    found_next = '0;
                    drop_next  = 1'b0;
                    case (mode_t'(mode))
                        MODE_LOOKUP:
                        begin
                            best_key_next = '0;
                            best_off_next = '0;
                            if (cnt_reg == '0)
                            begin
                                state_next = S_LK_REC1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = last_addr;
                                pend_next  = last_addr;
                                state_next = S_LK_SCAN;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                pend_next  = '0;
                                state_next = S_INS_SCAN;
                            end
                        end
                        MODE_RECENT:
                        begin
                            recent_key_next = time_key;
                            recent_off_next = offset_value;
                            state_next      = S_FIN;
                        end
                        MODE_SHIFT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                state_next = S_SH_REC;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                pend_next  = '0;
                                state_next = S_SH_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Walk down from the top entry until key <= query
            S_LK_SCAN:
            begin
                if (!alu_res.gt)
                begin
                    best_key_next = rd_key;
                    best_off_next = rd_off;
                    state_next    = S_LK_REC1;
                end
                else if (pend_reg == '0)
                begin
                    state_next = S_LK_REC1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = pend_reg - AW'(1);
                    pend_next  = pend_reg - AW'(1);
                end
            end

            // Recent key above the query: table candidate stands
            S_LK_REC1:
            begin
                if (alu_res.gt)
                begin
                    found_next = best_off_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_LK_REC2;
                end
            end

            // Recent pair wins unless the candidate key is above it
            S_LK_REC2:
            begin
                found_next = alu_res.gt ? best_off_reg : recent_off_reg;
                state_next = S_FIN;
            end

            // Walk up to an equal key or the first greater key
            S_INS_SCAN:
            begin
                if (alu_res.eq)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pend_reg;
                    ram_wdata  = {q_key_reg, val_reg};
                    state_next = S_FIN;
                end
                else
                begin
                    if (alu_res.gt)
                    begin
                        hit_done = 1'b1;
                        hit_pos  = CW'(pend_reg);
                    end
                    else if (pend_reg == last_addr)
                    begin
                        hit_done = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = pend_reg + AW'(1);
                        pend_next = pend_reg + AW'(1);
                    end

                    if (hit_done)
                    begin
                        pos_next = hit_pos;
                        if (table_full)
                        begin
                            drop_next  = 1'b1;
                            state_next = S_FIN;
                        end
                        else if (hit_pos == cnt_reg)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = last_addr;
                            pend_next  = last_addr;
                            state_next = S_INS_MOVE;
                        end
                    end
                end
            end

            // Move entries up by one, top first
            S_INS_MOVE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pend_reg + AW'(1);
                ram_wdata = ram_rdata;
                if (CW'(pend_reg) == pos_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pend_reg - AW'(1);
                    pend_next = pend_reg - AW'(1);
                end
            end

            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = {q_key_reg, val_reg};
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_FIN;
            end

            // Read-modify-write of every entry keyed after the threshold
            S_SH_SCAN:
            begin
                if (alu_res.gt)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_reg;
                    ram_wdata = {rd_key, alu_res.sum};
                end
                if (pend_reg == last_addr)
                begin
                    state_next = S_SH_REC;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pend_reg + AW'(1);
                    pend_next = pend_reg + AW'(1);
                end
            end

            S_SH_REC:
            begin
                if (alu_res.gt)
                begin
                    recent_off_next = alu_res.sum;
                end
                state_next = S_FIN;
            end

            // Hand the item to the output register once it is free
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    found_offset_next = found_reg;
                    dropped_next      = drop_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            q_key_reg        <= '0;
            val_reg          <= '0;
            cnt_reg          <= '0;
            pend_reg         <= '0;
            pos_reg          <= '0;
            best_key_reg     <= '0;
            best_off_reg     <= '0;
            found_reg        <= '0;
            drop_reg         <= 1'b0;
            recent_key_reg   <= '0;
            recent_off_reg   <= '0;
            out_valid_reg    <= 1'b0;
            found_offset_reg <= '0;
            dropped_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            q_key_reg        <= q_key_next;
            val_reg          <= val_next;
            cnt_reg          <= cnt_next;
            pend_reg         <= pend_next;
            pos_reg          <= pos_next;
            best_key_reg     <= best_key_next;
            best_off_reg     <= best_off_next;
            found_reg        <= found_next;
            drop_reg         <= drop_next;
            recent_key_reg   <= recent_key_next;
            recent_off_reg   <= recent_off_next;
            out_valid_reg    <= out_valid_next;
            found_offset_reg <= found_offset_next;
            dropped_reg      <= dropped_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign found_offset = found_offset_reg;
    assign dropped      = dropped_reg;

endmodule

// ===== design/sto_ram.sv =====
module sto_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sto_alu.sv =====
module sto_alu
    import sto_pkg::*;
(
    input  alu_op_t  op,
    output alu_res_t res
);

    logic [OFF_W:0] wide_sum;

    // Unsigned key compare and saturating offset add
    assign wide_sum = {1'b0, op.a} + {1'b0, op.b};
    assign res.gt   = (op.x > op.y);
    assign res.eq   = (op.x == op.y);
    assign res.sum  = wide_sum[OFF_W] ? {OFF_W{1'b1}} : wide_sum[OFF_W-1:0];

endmodule
